### rtl/fcl_pkg.sv
// Shared types and constants for the biphase-mark code line decoder.
`timescale 1ns / 1ps
package fcl_pkg;

   localparam int CODE_BITS  = 40;
   localparam int COUNT_W    = 6;
   localparam int DATA_W     = 20;
   localparam int STATUS_W   = 3;
   localparam int SAMPLE_W   = 16;
   localparam int HALF_W     = 8;
   localparam int START_W    = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int RSP_DATA_W = 32;

   // Line decoder phases
   localparam logic [1:0] PH_SEEK  = 2'd0;
   localparam logic [1:0] PH_RUN   = 2'd1;
   localparam logic [1:0] PH_CLOSE = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   // Framing patterns of the code word
   localparam logic [3:0] SYNC_NIBBLE  = 4'd3;
   localparam logic [6:0] LEAD_PATTERN = 7'd114;
   localparam logic [6:0] TRAIL_PATTERN = 7'd13;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_BITS   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FEW_BITS  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FRAMING   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_PARITY    = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLACK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START  = 2'd3;

   typedef struct packed {
      logic level;
      logic last;
   } item_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic [COUNT_W-1:0]   bits;
   } line_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  bit_count;
      logic                field_flag;
      logic [DATA_W-1:0]   data_value;
      logic                valid_res;
   } result_type;

endpackage

### rtl/fcl_slicer.sv
// Input register with level slicing at the white/black midpoint.
`timescale 1ns / 1ps
module fcl_slicer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [fcl_pkg::SAMPLE_W-1:0] sample,
   input  logic                         line_end,
   input  logic [fcl_pkg::SAMPLE_W-1:0] white_level,
   input  logic [fcl_pkg::SAMPLE_W-1:0] black_level,
   input  logic                         take,
   output logic                         item_valid,
   output fcl_pkg::item_type            item
);
   import fcl_pkg::*;

   logic [SAMPLE_W:0]   level_sum;
   logic [SAMPLE_W-1:0] midpoint;
   logic                valid_ff;
   logic                valid_in;
   item_type            item_ff;
   item_type            item_in;
   logic                accept;

   assign level_sum = {1'b0, white_level} + {1'b0, black_level};
   assign midpoint  = level_sum[SAMPLE_W:1];
   assign in_ready  = !valid_ff || take;
   assign accept    = in_valid && in_ready;

   always_comb begin
      item_in       = item_ff;
      item_in.level = (sample > midpoint);
      item_in.last  = line_end;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### rtl/fcl_core.sv
// Line state: start search, edge interval timing and bit shifting.
`timescale 1ns / 1ps
module fcl_core #(
   parameter int LINE_SAMPLES_MAX = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  fcl_pkg::item_type           item,
   input  logic [fcl_pkg::HALF_W-1:0]  half_cell_samples,
   input  logic [fcl_pkg::START_W-1:0] active_start,
   output fcl_pkg::line_type           line_next
);
   import fcl_pkg::*;

   localparam int IDX_W = $clog2(LINE_SAMPLES_MAX + 1);
   localparam int CMP_W = (IDX_W > START_W) ? IDX_W : START_W;

   logic [1:0]           phase_ff, phase_in;
   logic                 level_ff, level_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     ref_ff, ref_in;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic [COUNT_W-1:0]   bits_ff, bits_in;
   logic [IDX_W-1:0]     gap;
   logic                 short_gap;
   logic                 start_ok;

   assign gap       = idx_ff - ref_ff;
   assign short_gap = gap < IDX_W'(half_cell_samples);
   assign start_ok  = CMP_W'(idx_ff) >= CMP_W'(active_start);

   always_comb begin
      phase_in = phase_ff;
      level_in = level_ff;
      idx_in   = idx_ff;
      ref_in   = ref_ff;
      code_in  = code_ff;
      bits_in  = bits_ff;
      if (idx_ff < IDX_W'(LINE_SAMPLES_MAX)) begin
         unique case (phase_ff)
            PH_SEEK: begin
               if (start_ok && item.level) begin
                  phase_in = PH_RUN;
                  level_in = 1'b1;
                  ref_in   = idx_ff;
               end
            end
            PH_RUN: begin
               if (item.level != level_ff) begin
                  level_in = item.level;
                  code_in  = {code_ff[CODE_BITS-2:0], short_gap};
                  bits_in  = bits_ff + 1'b1;
                  ref_in   = idx_ff;
                  phase_in = short_gap ? PH_CLOSE : PH_RUN;
                  if (bits_in >= COUNT_W'(CODE_BITS)) begin
                     phase_in = PH_DONE;
                  end
               end
            end
            PH_CLOSE: begin
               if (item.level != level_ff) begin
                  level_in = item.level;
                  ref_in   = idx_ff;
                  phase_in = PH_RUN;
               end
            end
            default: begin
            end
         endcase
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last)) begin
         phase_ff <= PH_SEEK;
         level_ff <= 1'b0;
         idx_ff   <= '0;
         ref_ff   <= '0;
         code_ff  <= '0;
         bits_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         idx_ff   <= idx_in;
         ref_ff   <= ref_in;
         code_ff  <= code_in;
         bits_ff  <= bits_in;
      end
   end

   assign line_next.code = code_in;
   assign line_next.bits = bits_in;

   dec_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= COUNT_W'(CODE_BITS))
      else $error("decoded bit count above code length");
   dec_done_full: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> (bits_ff == COUNT_W'(CODE_BITS)))
      else $error("done phase without a full code word");
   dec_index_sat: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(LINE_SAMPLES_MAX))
      else $error("sample index past saturation");

endmodule

### rtl/fcl_check.sv
// Code word checks: bit count, framing, odd parity, field extraction.
`timescale 1ns / 1ps
module fcl_check (
   input  fcl_pkg::line_type   line_word,
   output fcl_pkg::result_type result
);
   import fcl_pkg::*;

   logic [CODE_BITS-1:0] w;
   logic [DATA_W-1:0]    data;
   logic                 parity_ok;
   logic                 framing_ok;
   logic [STATUS_W-1:0]  status;

   assign w          = line_word.code;
   assign data       = w[27:8];
   assign parity_ok  = ^{data, w[7]};
   assign framing_ok = (w[39:36] == SYNC_NIBBLE) && (w[34:28] == LEAD_PATTERN)
                       && (w[6:0] == TRAIL_PATTERN);

   always_comb begin
      priority if (line_word.bits == '0) begin
         status = ST_NO_BITS;
      end else if (line_word.bits != COUNT_W'(CODE_BITS)) begin
         status = ST_FEW_BITS;
      end else if (!framing_ok) begin
         status = ST_FRAMING;
      end else if (!parity_ok) begin
         status = ST_PARITY;
      end else begin
         status = ST_OK;
      end
      result.status     = status;
      result.bit_count  = line_word.bits;
      result.valid_res  = (status == ST_OK);
      result.data_value = (status == ST_OK) ? data : '0;
      result.field_flag = (status == ST_OK) ? w[35] : 1'b0;
   end

endmodule

### rtl/fm_code_line_decoder.sv
// Top level of the biphase-mark code line decoder.
`timescale 1ns / 1ps
// A line-end request passes the input register and then the result register before its result shows on rsp.
// Throughput: one request per cycle; a stalled rsp holds back only a line-end request
// that finds the result register still full (one result register parts the sides).
// Reset: config returns to white 65535, black 0, half cell 10, start 0; line state
// clears to start-search and is cleared again after every line end.
module fm_code_line_decoder #(
   parameter int LINE_SAMPLES_MAX = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,   // [15:0] sample
   input  logic                           req_tlast,   // line_end
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] valid_res, [20:1] data_value, [21] field_flag, [27:22] bit_count,
   // [30:28] status, [31] zero
   output logic [fcl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fcl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                    csr_data
);
   import fcl_pkg::*;

   logic [SAMPLE_W-1:0] white_ff, black_ff;
   logic [HALF_W-1:0]   half_ff;
   logic [START_W-1:0]  start_ff;

   logic       item_valid;
   item_type   item;
   logic       out_free;
   logic       take;
   line_type   line_next;
   result_type result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   // Configuration writes always complete; the user must send them only while idle (not enforced).
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff <= 16'hFFFF;
         black_ff <= '0;
         half_ff  <= 8'd10;
         start_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WHITE: white_ff <= csr_data;
            CSR_BLACK: black_ff <= csr_data;
            CSR_HALF:  half_ff  <= csr_data[HALF_W-1:0];
            CSR_START: start_ff <= csr_data[START_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Slice on the way in and hold the request in the input register.
   fcl_slicer u_slicer (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .sample      (req_tdata),
      .line_end    (req_tlast),
      .white_level (white_ff),
      .black_level (black_ff),
      .take        (take),
      .item_valid  (item_valid),
      .item        (item)
   );

   // Advance the line state on every taken request; a line-end request waits for room in
   // the result register.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign take     = item_valid && (!item.last || out_free);

   fcl_core #(
      .LINE_SAMPLES_MAX (LINE_SAMPLES_MAX)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .step              (take),
      .item              (item),
      .half_cell_samples (half_ff),
      .active_start      (start_ff),
      .line_next         (line_next)
   );

   fcl_check u_check (
      .line_word (line_next),
      .result    (result)
   );

   // Result register: load on a line-end request, drop once taken.
   always_comb begin
      if (take && item.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && item.last) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   top_ok_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.valid_res == (rsp_data_ff.status == ST_OK)))
      else $error("valid_res disagrees with status");
   top_fail_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_OK) |->
         (rsp_data_ff.data_value == '0 && !rsp_data_ff.field_flag))
      else $error("failed line carries data");
   top_new_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(take && item.last))
      else $error("result without a line-end request");
   top_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(take && item.last))
      else $error("line-end request taken over a held result");

endmodule
